>>> rtl/core/bwst_pkg.sv
`default_nettype none

package bwst_pkg;

    localparam int AMT_W = 32;
    localparam int SUM_W = 42;
    localparam int POS_W = 16;
    localparam int LEN_W = 11;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [AMT_W-1:0] sale_cents;
        logic             last_sale;
    } sale_t;

    typedef struct packed {
        logic             window_full;
        logic [POS_W-1:0] best_start;
        logic [SUM_W-1:0] best_sum;
    } result_t;

    // one classified item on its way from front to back
    typedef struct packed {
        logic [AMT_W-1:0] amount;
        logic [AMT_W-1:0] old_amount;   // amount leaving the window
        logic             last;
        logic             do_sum;       // window length is usable
        logic             drop_old;     // window was already full before this item
        logic             fill_now;     // this item completes the first window
        logic [POS_W-1:0] start;        // start index of the window ending here
    } work_t;

endpackage

`default_nettype wire

>>> rtl/core/bwst_ram.sv
`default_nettype none

module bwst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/bwst_front.sv
`default_nettype none

module bwst_front #(
    parameter int MAX_WINDOW = 1024,
    parameter int DEPTH = 4,
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int LW = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [bwst_pkg::LEN_W-1:0]  cfg_data,
    input  wire logic                        sale_valid,
    output logic                             sale_stall,
    input  wire bwst_pkg::sale_t             sale,
    input  wire logic [LW-1:0]               level,
    output logic                             push,
    output bwst_pkg::work_t                  push_item
);

    logic [bwst_pkg::LEN_W-1:0] len_reg, len_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [bwst_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       filled_reg, filled_next;
    logic                       s1_valid_reg;
    bwst_pkg::work_t            s1_reg, s1_next;

    logic                       accept;
    logic                       len_ok;
    logic [31:0]                ptr_inc;
    logic [bwst_pkg::POS_W:0]   pos_inc;
    logic                       fill_now;
    logic [bwst_pkg::AMT_W-1:0] rdata;

    // room is counted against the item whose old amount is still being read
    assign sale_stall = (32'(level) + 32'(s1_valid_reg)) >= 32'(DEPTH);
    assign accept     = sale_valid && !sale_stall;

    assign len_ok   = (len_reg != '0) && (32'(len_reg) <= 32'(MAX_WINDOW));
    assign ptr_inc  = 32'(ptr_reg) + 32'd1;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign fill_now = len_ok && !filled_reg
                      && (pos_inc >= (bwst_pkg::POS_W + 1)'(len_reg));

    always_comb
    begin
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        filled_next = filled_reg;
        priority if (cfg_write)
        begin
            len_next    = cfg_data;
            ptr_next    = '0;
            pos_next    = '0;
            filled_next = 1'b0;
        end
        else if (accept)
        begin
            if (sale.last_sale)
            begin
                ptr_next    = '0;
                pos_next    = '0;
                filled_next = 1'b0;
            end
            else
            begin
                if (len_ok)
                begin
                    ptr_next = (ptr_inc >= 32'(len_reg)) ? '0 : AW'(ptr_inc);
                end
                if (pos_reg != bwst_pkg::POS_MAX)
                begin
                    pos_next = pos_inc[bwst_pkg::POS_W-1:0];
                end
                filled_next = filled_reg || fill_now;
            end
        end
    end

    always_comb
    begin
        s1_next            = s1_reg;
        s1_next.amount     = sale.sale_cents;
        s1_next.old_amount = '0;
        s1_next.last       = sale.last_sale;
        s1_next.do_sum     = len_ok;
        s1_next.drop_old   = len_ok && filled_reg;
        s1_next.fill_now   = fill_now;
        s1_next.start      = bwst_pkg::POS_W'(pos_inc - (bwst_pkg::POS_W + 1)'(len_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= bwst_pkg::LEN_W'(1);
            ptr_reg      <= '0;
            pos_reg      <= '0;
            filled_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            ptr_reg      <= ptr_next;
            pos_reg      <= pos_next;
            filled_reg   <= filled_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    bwst_ram #(
        .WIDTH (bwst_pkg::AMT_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (accept && len_ok),
        .waddr (ptr_reg),
        .wdata (sale.sale_cents),
        .re    (accept),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    assign push = s1_valid_reg;

    always_comb
    begin
        push_item            = s1_reg;
        push_item.old_amount = rdata;
    end

endmodule

`default_nettype wire

>>> rtl/core/bwst_fifo.sv
`default_nettype none

module bwst_fifo #(
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LW = $clog2(DEPTH + 1)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire bwst_pkg::work_t push_item,
    input  wire logic            pop,
    output bwst_pkg::work_t      head,
    output logic                 empty,
    output logic [LW-1:0]        level
);

    bwst_pkg::work_t entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]   count_reg, count_next;

    // the front never pushes into a full queue
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign level = count_reg;

endmodule

`default_nettype wire

>>> rtl/core/bwst_back.sv
`default_nettype none

module bwst_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_write,
    input  wire logic            empty,
    input  wire bwst_pkg::work_t head,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output bwst_pkg::result_t    result
);

    typedef struct packed {
        logic [bwst_pkg::SUM_W-1:0] sum;
        logic                       last;
        logic                       do_sum;
        logic                       drop_old;
        logic                       fill_now;
        logic [bwst_pkg::POS_W-1:0] start;
    } sum_item_t;

    logic                       advance;
    logic [bwst_pkg::SUM_W-1:0] rs_reg, rs_next;
    logic [bwst_pkg::SUM_W-1:0] rs_base, rs_new;
    logic                       b_valid_reg;
    sum_item_t                  b_reg, b_next;
    logic [bwst_pkg::SUM_W-1:0] top_sum_reg, top_sum_next, top_sum_new;
    logic [bwst_pkg::POS_W-1:0] top_start_reg, top_start_next, top_start_new;
    logic                       full;
    logic                       out_valid_reg;
    bwst_pkg::result_t          out_reg, out_next;

    // the whole back end holds while a result waits
    assign advance = !(out_valid_reg && result_stall);
    assign pop     = advance && !empty;

    // running window sum
    assign rs_base = head.drop_old ? rs_reg - bwst_pkg::SUM_W'(head.old_amount) : rs_reg;
    assign rs_new  = rs_base + bwst_pkg::SUM_W'(head.amount);

    always_comb
    begin
        rs_next = rs_reg;
        priority if (cfg_write)
        begin
            rs_next = '0;
        end
        else if (pop && head.last)
        begin
            rs_next = '0;
        end
        else if (pop && head.do_sum)
        begin
            rs_next = rs_new;
        end
    end

    always_comb
    begin
        b_next.sum      = rs_new;
        b_next.last     = head.last;
        b_next.do_sum   = head.do_sum;
        b_next.drop_old = head.drop_old;
        b_next.fill_now = head.fill_now;
        b_next.start    = head.start;
    end

    // best window; a tie keeps the earlier one
    always_comb
    begin
        top_sum_new   = top_sum_reg;
        top_start_new = top_start_reg;
        priority if (b_reg.do_sum && b_reg.fill_now)
        begin
            top_sum_new   = b_reg.sum;
            top_start_new = '0;
        end
        else if (b_reg.do_sum && b_reg.drop_old && (b_reg.sum > top_sum_reg))
        begin
            top_sum_new   = b_reg.sum;
            top_start_new = b_reg.start;
        end
        full = b_reg.fill_now || b_reg.drop_old;

        out_next.window_full = full;
        out_next.best_start  = full ? top_start_new : '0;
        out_next.best_sum    = full ? top_sum_new : '0;

        top_sum_next   = top_sum_reg;
        top_start_next = top_start_reg;
        priority if (cfg_write)
        begin
            top_sum_next   = '0;
            top_start_next = '0;
        end
        else if (advance && b_valid_reg)
        begin
            top_sum_next   = b_reg.last ? '0 : top_sum_new;
            top_start_next = b_reg.last ? '0 : top_start_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg        <= '0;
            top_sum_reg   <= '0;
            top_start_reg <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rs_reg        <= rs_next;
            top_sum_reg   <= top_sum_next;
            top_start_reg <= top_start_next;
            if (advance)
            begin
                b_valid_reg   <= pop;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_reg <= b_next;
        end
        if (advance && b_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/best_window_sum_tracker.sv
// Best fixed-length window sum tracker.
// sale channel: one amount in cents per item, with last_sale closing the series.
// result channel: one item per sale item, in order: window_full, the start index
// of the best window so far (earliest wins ties) and its sum; both are 0 until
// window_len amounts of the series have arrived.
// cfg_write/cfg_data sets window_len and clears the series; write it only
// while nothing is in flight. A length of 0 or above MAX_WINDOW gives no window.
// A result passes the front register, the queue, b_reg and out_reg in turn.
// Throughput: one item per cycle unless sale_stall is high; the window
// sum needs a single ring memory read per item, in the cycle the item is taken.
// A front end takes items and reads the departing amount; a queue of
// QUEUE_DEPTH items decouples it from the back end that sums and compares.
// When result_stall is held the back end freezes, the queue fills and
// sale_stall rises once the queue plus the item in its read cycle are full.
// Reset (rst_n, asynchronous) clears the series and sets window_len to 1;
// the ring memory is not cleared and needs no start-up pass.
`default_nettype none

module best_window_sum_tracker #(
    parameter int MAX_WINDOW = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [bwst_pkg::LEN_W-1:0] cfg_data,
    input  wire logic                       sale_valid,
    output logic                            sale_stall,
    input  wire bwst_pkg::sale_t            sale,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output bwst_pkg::result_t               result
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic            push;
    bwst_pkg::work_t push_item;
    logic            pop;
    bwst_pkg::work_t head;
    logic            empty;
    logic [LW-1:0]   level;

    bwst_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .DEPTH      (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .sale_valid (sale_valid),
        .sale_stall (sale_stall),
        .sale       (sale),
        .level      (level),
        .push       (push),
        .push_item  (push_item)
    );

    bwst_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .level     (level)
    );

    bwst_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> rtl/core/bwst_checker.sv
`default_nettype none

module bwst_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire bwst_pkg::result_t result
);

    // a held result keeps its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // no best window is reported before the first window is complete
    a_not_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.window_full |->
            (result.best_start == '0) && (result.best_sum == '0))
        else $error("best fields set without a full window");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !result_valid)
        else $error("result valid straight after reset");

endmodule

bind best_window_sum_tracker bwst_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

>>> sim/best_window_sum_checker.sv
module best_window_sum_checker
    import bwst_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             sale_valid,
    input  logic             sale_stall,
    input  sale_t            sale,
    input  logic             result_valid,
    input  logic             result_stall,
    input  result_t          result,
    output int               fail_count,
    output int               awaited,
    output int               sales_taken
);

    logic [AMT_W-1:0] amount_ring [MAX_WINDOW];
    logic [SUM_W-1:0] window_total;
    logic [SUM_W-1:0] best_total;
    logic [POS_W-1:0] best_idx;
    logic [POS_W-1:0] sale_pos;
    int unsigned      ring_wr;
    bit               have_window;
    logic [LEN_W-1:0] win_len;

    result_t expected_results[$];
    int      fails;
    int      taken;

    function automatic void clear_series();
        window_total = '0;
        best_total   = '0;
        best_idx     = '0;
        sale_pos     = '0;
        ring_wr      = 0;
        have_window  = 1'b0;
    endfunction

    // one sale item through the window tracker, returns its result
    function automatic result_t advance_window(input sale_t s);
        int unsigned k;
        int unsigned idx;
        int unsigned p;
        result_t     r;
        k   = win_len;
        idx = sale_pos;
        if (k >= 1 && k <= MAX_WINDOW) begin
            p = ring_wr;
            if (p >= MAX_WINDOW)
                p = 0;
            if (have_window)
                window_total = window_total - amount_ring[p];
            window_total   = window_total + s.sale_cents;
            amount_ring[p] = s.sale_cents;
            p++;
            ring_wr = (p >= k) ? 0 : p;
            if (!have_window) begin
                if (idx + 1 >= k) begin
                    have_window = 1'b1;
                    best_total  = window_total;
                    best_idx    = '0;
                end
            end else if (window_total > best_total) begin
                best_total = window_total;
                best_idx   = POS_W'(idx + 1 - k);
            end
        end
        // index freezes once the counter saturates
        if (sale_pos != POS_MAX)
            sale_pos++;
        r.window_full = have_window;
        r.best_start  = have_window ? best_idx : '0;
        r.best_sum    = have_window ? best_total : '0;
        if (s.last_sale)
            clear_series();
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            win_len = LEN_W'(1);
            clear_series();
            expected_results.delete();
        end else begin
            if (result_valid && !result_stall) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("window_full", want.window_full, result.window_full);
                    compare_field("best_start", want.best_start, result.best_start);
                    compare_field("best_sum", want.best_sum, result.best_sum);
                end
            end
            if (cfg_write) begin
                win_len = cfg_data;
                clear_series();
            end
            if (sale_valid && !sale_stall) begin
                expected_results.push_back(advance_window(sale));
                taken++;
            end
        end
        awaited     <= expected_results.size();
        fail_count  <= fails;
        sales_taken <= taken;
    end

endmodule

>>> sim/tb_best_window_sum_tracker.sv
module tb_best_window_sum_tracker;
    import bwst_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 80;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_write    = 1'b0;
    logic [LEN_W-1:0] cfg_data     = '0;
    logic             sale_valid   = 1'b0;
    logic             sale_stall;
    sale_t            sale         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;

    int fail_count;
    int awaited;
    int sales_taken;
    int settings_used;
    bit no_idle    = 1'b0;
    int hold_asks  = 0;
    int holds_done = 0;

    best_window_sum_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .sale_valid   (sale_valid),
        .sale_stall   (sale_stall),
        .sale         (sale),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    best_window_sum_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .sale_valid   (sale_valid),
        .sale_stall   (sale_stall),
        .sale         (sale),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .awaited      (awaited),
        .sales_taken  (sales_taken)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, plus a long hold when asked
    initial
    begin
        int run;
        forever
        begin
            if (hold_asks != holds_done) begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end else begin
                result_stall <= !no_idle && ($urandom_range(0, 3) == 0);
                run = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(1, 3);
                repeat (run) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 15);
            4, 5, 6:    return $urandom();
            7:          return '1;
            8:          return '0;
            default:    return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len(input bit bad);
        int r;
        r = $urandom_range(0, 9);
        if (bad || r == 9)
            return ($urandom_range(0, 1) == 0) ? LEN_W'(0) : LEN_W'($urandom_range(1025, 2047));
        if (r < 6)
            return LEN_W'($urandom_range(1, 6));
        if (r < 8)
            return LEN_W'($urandom_range(7, 40));
        return LEN_W'($urandom_range(100, 200));
    endfunction

    task automatic send_sale(input logic [AMT_W-1:0] amount, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sale_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sale_valid <= 1'b1;
        sale       <= '{sale_cents: amount, last_sale: last};
        do @(posedge clk); while (sale_stall);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        sale_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [LEN_W-1:0] len);
        drain();
        cfg_data  <= len;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int unsigned k;
        int left;
        int series;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of one straight out of reset
        send_sale('0, 1'b0);
        send_sale('1, 1'b0);
        send_sale(32'd5, 1'b1);

        // ties keep the earliest window
        set_window(LEN_W'(3));
        for (int i = 0; i < 5; i++)
            send_sale(32'd5, 1'b0);
        send_sale(32'd9, 1'b0);
        send_sale(32'd0, 1'b0);
        send_sale(32'd0, 1'b0);
        send_sale(32'd1, 1'b1);
        // new series too short to fill
        send_sale(32'd7, 1'b0);
        send_sale(32'd7, 1'b1);

        // unusable lengths
        set_window(LEN_W'(0));
        send_sale(32'd3, 1'b0);
        send_sale(32'd4, 1'b1);
        set_window(LEN_W'(1025));
        send_sale('1, 1'b1);
        set_window('1);
        send_sale(32'd8, 1'b1);

        // full-scale amounts, window sums reach the top bit of the sum
        set_window(LEN_W'(520));
        no_idle = 1'b1;
        for (int i = 0; i < 4; i++)
            send_sale('0, 1'b0);
        for (int i = 0; i < 524; i++)
            send_sale('1, i == 523);
        no_idle = 1'b0;

        for (int ph = 0; ph < 6; ph++)
        begin
            set_window(pick_len(ph == 4));
            k = cfg_data;
            no_idle = (ph == 3);
            if (ph == 3)
                hold_asks++;
            left = 40;
            while (left > 0)
            begin
                if (k < 1 || k > 1024)
                    series = $urandom_range(1, 8);
                else if ($urandom_range(0, 3) != 0)
                    series = k + $urandom_range(0, 2 * k + 4);
                else
                    series = $urandom_range(1, k);
                for (int i = 0; i < series; i++)
                    send_sale(pick_amount(), i == series - 1);
                left -= series;
                // sender waits out every result mid-phase
                if (ph == 5 && left > 0 && left <= 60)
                    drain();
            end
        end

        drain();
        $display("Run covered %0d sale items over %0d window settings,", sales_taken,
                 settings_used);
        $display("including unusable lengths, full-scale sums, a long result hold and a drain.");
        if (fail_count == 0 && awaited == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
